FILE: rtl/region_box_blur_3x3_assert.svh
// Assertion macros shared by the region box blur RTL.
`ifndef REGION_BOX_BLUR_3X3_ASSERT_SVH
`define REGION_BOX_BLUR_3X3_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define RBB_ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, checked at every rising edge outside reset.
`define RBB_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define RBB_ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg)
`define RBB_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: rtl/rbb_pkg.sv
// Shared types and constants of the region box blur.
package rbb_pkg;

	// Sample format and the smallest matrix side.
	localparam int SAMPLE_W = 16;
	localparam int MIN_DIM = 4;

	// Register map: index = paddr[4:2].
	localparam int ADDR_W = 5;
	localparam int REG_IDX_W = 3;
	localparam logic [REG_IDX_W-1:0] REG_NUM_ROWS = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_NUM_COLS = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_ROW_FIRST = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_ROW_LAST = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_COL_FIRST = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_COL_LAST = 3'd5;

	// Queue between front and back.
	localparam int QUEUE_DEPTH = 4;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	// Arithmetic widths of the mean datapath.
	localparam int COLSUM_W = 18;
	localparam int SUM_W = 20;
	localparam int MAG_W = 19;
	localparam int QUO_W = 17;
	localparam int RECIP_W = 21;
	localparam int PROD_W = MAG_W + RECIP_W;
	localparam int RECIP_SHIFT = 23;

	// ceil(2^23 / d); exact quotient for every dividend below 2^19.
	localparam logic [RECIP_W-1:0] RECIP_6 = 21'd1398102;
	localparam logic [RECIP_W-1:0] RECIP_9 = 21'd932068;

	// Rounding offsets, half the divisor rounded down.
	localparam logic [MAG_W-1:0] BIAS_4 = 19'd2;
	localparam logic [MAG_W-1:0] BIAS_6 = 19'd3;
	localparam logic [MAG_W-1:0] BIAS_9 = 19'd4;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	// Number of window cells that lie inside the matrix.
	typedef enum logic [1:0] {
		DIV_BY_4,
		DIV_BY_6,
		DIV_BY_9
	} div_t;

	// Blur rectangle, inclusive on both axes.
	typedef struct packed {
		logic [5:0] row_first;
		logic [5:0] row_last;
		logic [4:0] col_first;
		logic [4:0] col_last;
	} region_t;

	// One queue word: a window column to shift in and what to emit after it.
	typedef struct packed {
		sample_t top;
		sample_t mid;
		sample_t bot;
		logic    emit;
		logic    blur;
		logic    top_ok;
		logic    bot_ok;
		logic    left_ok;
		logic    right_ok;
		logic    fe;
	} entry_t;

endpackage

FILE: rtl/rbb_fifo.sv
// Short word queue between the front sequencer and the back datapath.
`include "region_box_blur_3x3_assert.svh"
module rbb_fifo
	import rbb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  entry_t            push_data,
	input  logic              pop,
	output entry_t            head,
	output logic              empty,
	output logic [QCNT_W-1:0] count
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	entry_t            slots_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	// Storage, written at the tail.
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			case ({push, pop})
				2'b10: count_q <= count_q + QCNT_W'(1);
				2'b01: count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	assign head  = slots_q[rd_ptr_q];
	assign empty = (count_q == '0);
	assign count = count_q;

	`RBB_ASSERT_IMPLY(a_no_overflow, clk, arst_n, push, count_q < QCNT_W'(QUEUE_DEPTH), "queue overflow")
	`RBB_ASSERT_IMPLY(a_no_underflow, clk, arst_n, pop, count_q != '0, "queue underflow")

endmodule

FILE: rtl/rbb_front.sv
// Front sequencer: accepts samples, keeps the line stores and issues window columns.
`include "region_box_blur_3x3_assert.svh"
module rbb_front
	import rbb_pkg::*;
#(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 32
)(
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        restart,
	input  logic [$clog2(MAX_ROWS)-1:0] row_last,
	input  logic [$clog2(MAX_COLS)-1:0] col_last,
	input  region_t                     region,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [SAMPLE_W-1:0]         s_tdata,
	input  logic [QCNT_W-1:0]           q_count,
	output logic                        push,
	output entry_t                      push_data
);

	localparam int ROW_W = $clog2(MAX_ROWS);
	localparam int COL_W = $clog2(MAX_COLS);
	localparam int FL_W = QCNT_W + 1;

	// Each state issues one queue word per cycle while the queue has room and, in ST_RUN, a sample is offered.
	typedef enum logic [1:0] {
		ST_RUN,
		ST_ROW_END,
		ST_FLUSH,
		ST_FLUSH_END
	} state_t;

	state_t           state_q;
	state_t           op_s1;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;
	logic [COL_W-1:0] col_s1;
	logic             valid_s1;
	sample_t          sample_s1;
	sample_t          up_s1;
	sample_t          lo_s1;
	logic             emit_s1;
	logic             blur_s1;
	logic             top_ok_s1;
	logic             bot_ok_s1;
	logic             left_ok_s1;
	logic             right_ok_s1;
	logic             fe_s1;

	sample_t          upper_q [MAX_COLS];
	sample_t          lower_q [MAX_COLS];

	logic [FL_W-1:0]  in_flight;
	logic             space;
	logic             issue;
	logic [ROW_W-1:0] op_row;
	logic [COL_W-1:0] op_col;
	logic             d_emit;
	logic             d_blur;
	logic             d_top_ok;
	logic             d_bot_ok;
	logic             d_left_ok;
	logic             d_right_ok;
	logic             d_fe;

	// Credit: queue words plus the one in stage 1 must leave a free slot.
	assign in_flight = FL_W'(q_count) + FL_W'(valid_s1);
	assign space     = in_flight < FL_W'(QUEUE_DEPTH);
	assign issue     = space && ((state_q != ST_RUN) || s_tvalid);
	assign s_tready  = space && (state_q == ST_RUN);

	// Which element the issued word emits, and which neighbors are inside the matrix.
	always_comb begin
		op_row     = row_q - ROW_W'(1);
		op_col     = col_q - COL_W'(1);
		d_emit     = 1'b0;
		d_top_ok   = 1'b1;
		d_bot_ok   = 1'b1;
		d_left_ok  = 1'b1;
		d_right_ok = 1'b1;
		d_fe       = 1'b0;
		case (state_q)
			ST_RUN: begin
				d_emit    = (row_q != '0) && (col_q != '0);
				d_top_ok  = row_q > ROW_W'(1);
				d_left_ok = col_q > COL_W'(1);
			end
			ST_ROW_END: begin
				d_emit     = (row_q != '0);
				op_col     = col_last;
				d_top_ok   = row_q > ROW_W'(1);
				d_right_ok = 1'b0;
			end
			ST_FLUSH: begin
				d_emit    = (col_q != '0);
				op_row    = row_q;
				d_bot_ok  = 1'b0;
				d_left_ok = col_q > COL_W'(1);
			end
			ST_FLUSH_END: begin
				d_emit     = 1'b1;
				op_row     = row_q;
				op_col     = col_last;
				d_bot_ok   = 1'b0;
				d_right_ok = 1'b0;
				d_fe       = 1'b1;
			end
			default: begin
				d_emit = 1'b0;
			end
		endcase
		d_blur = (32'(op_row) >= 32'(region.row_first)) && (32'(op_row) <= 32'(region.row_last))
			&& (32'(op_col) >= 32'(region.col_first)) && (32'(op_col) <= 32'(region.col_last));
	end

	// Line stores: read at issue, written back in the next cycle by running samples.
	always_ff @(posedge clk) begin
		if (issue) begin
			up_s1 <= upper_q[col_q];
			lo_s1 <= lower_q[col_q];
		end
		if (valid_s1 && (op_s1 == ST_RUN)) begin
			upper_q[col_s1] <= lo_s1;
			lower_q[col_s1] <= sample_s1;
		end
	end

	// Sequencer state, counters and stage 1.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			row_q       <= '0;
			col_q       <= '0;
			valid_s1    <= 1'b0;
			op_s1       <= ST_RUN;
			col_s1      <= '0;
			sample_s1   <= '0;
			emit_s1     <= 1'b0;
			blur_s1     <= 1'b0;
			top_ok_s1   <= 1'b0;
			bot_ok_s1   <= 1'b0;
			left_ok_s1  <= 1'b0;
			right_ok_s1 <= 1'b0;
			fe_s1       <= 1'b0;
		end else begin
			valid_s1 <= issue;
			if (issue) begin
				op_s1       <= state_q;
				col_s1      <= col_q;
				sample_s1   <= sample_t'(s_tdata);
				emit_s1     <= d_emit;
				blur_s1     <= d_blur;
				top_ok_s1   <= d_top_ok;
				bot_ok_s1   <= d_bot_ok;
				left_ok_s1  <= d_left_ok;
				right_ok_s1 <= d_right_ok;
				fe_s1       <= d_fe;
			end
			if (restart) begin
				state_q <= ST_RUN;
				row_q   <= '0;
				col_q   <= '0;
			end else if (issue) begin
				case (state_q)
					ST_RUN: begin
						if (col_q == col_last) begin
							state_q <= ST_ROW_END;
						end else begin
							col_q <= col_q + COL_W'(1);
						end
					end
					ST_ROW_END: begin
						col_q <= '0;
						if (row_q == row_last) begin
							state_q <= ST_FLUSH;
						end else begin
							state_q <= ST_RUN;
							row_q   <= row_q + ROW_W'(1);
						end
					end
					ST_FLUSH: begin
						if (col_q == col_last) begin
							state_q <= ST_FLUSH_END;
						end else begin
							col_q <= col_q + COL_W'(1);
						end
					end
					ST_FLUSH_END: begin
						state_q <= ST_RUN;
						row_q   <= '0;
						col_q   <= '0;
					end
					default: begin
						state_q <= ST_RUN;
					end
				endcase
			end
		end
	end

	// Stage 1 pushes its word; running samples and flush reads carry store data.
	always_comb begin
		push               = valid_s1;
		push_data.top      = '0;
		push_data.mid      = '0;
		push_data.bot      = '0;
		push_data.emit     = emit_s1;
		push_data.blur     = blur_s1;
		push_data.top_ok   = top_ok_s1;
		push_data.bot_ok   = bot_ok_s1;
		push_data.left_ok  = left_ok_s1;
		push_data.right_ok = right_ok_s1;
		push_data.fe       = fe_s1;
		if ((op_s1 == ST_RUN) || (op_s1 == ST_FLUSH)) begin
			push_data.top = up_s1;
			push_data.mid = lo_s1;
		end
		if (op_s1 == ST_RUN) begin
			push_data.bot = sample_s1;
		end
	end

	`RBB_ASSERT_IMPLY(a_counters_in_frame, clk, arst_n, 1'b1, (col_q <= col_last) && (row_q <= row_last), "position counter beyond the frame")
	`RBB_ASSERT_NEXT(a_frame_wrap, clk, arst_n, issue && (state_q == ST_FLUSH_END), (state_q == ST_RUN) && (row_q == '0) && (col_q == '0), "frame did not wrap after the flush")

endmodule

FILE: rtl/rbb_back.sv
// Back datapath: 3x3 window, masked sum, rounded mean and the output register.
`include "region_box_blur_3x3_assert.svh"
module rbb_back
	import rbb_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  entry_t              head,
	input  logic                empty,
	output logic                pop,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [SAMPLE_W-1:0] m_tdata,
	output logic                m_tlast
);

	logic                       en;
	sample_t                    win_q [3][3];
	logic                       v_s1;
	entry_t                     ent_s1;

	logic signed [COLSUM_W-1:0] col_sum [3];
	div_t                       div_c;
	logic                       v_s2;
	logic signed [COLSUM_W-1:0] colsum_s2 [3];
	div_t                       div_s2;
	logic                       blur_s2;
	sample_t                    center_s2;
	logic                       fe_s2;

	logic signed [SUM_W-1:0]    sum;
	logic [SUM_W-1:0]           mag;
	logic [MAG_W-1:0]           bias;
	logic                       v_s3;
	logic [MAG_W-1:0]           x_s3;
	logic                       neg_s3;
	div_t                       div_s3;
	logic                       blur_s3;
	sample_t                    center_s3;
	logic                       fe_s3;

	logic [RECIP_W-1:0]         recip;
	logic [PROD_W-1:0]          prod;
	logic                       v_s4;
	logic [QUO_W-1:0]           q_s4;
	logic                       neg_s4;
	logic                       blur_s4;
	sample_t                    center_s4;
	logic                       fe_s4;

	logic [QUO_W-1:0]           res;
	logic                       m_tvalid_q;
	logic [SAMPLE_W-1:0]        m_tdata_q;
	logic                       m_tlast_q;

	// The whole pipeline moves while the output register is free or being taken.
	assign en  = !m_tvalid_q || m_tready;
	assign pop = en && !empty;

	// Stage 2: masked column sums and the number of cells inside the matrix.
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			col_sum[k] = COLSUM_W'(win_q[1][k]);
			if (ent_s1.top_ok) begin
				col_sum[k] = col_sum[k] + COLSUM_W'(win_q[0][k]);
			end
			if (ent_s1.bot_ok) begin
				col_sum[k] = col_sum[k] + COLSUM_W'(win_q[2][k]);
			end
		end
		if (!ent_s1.left_ok) begin
			col_sum[0] = '0;
		end
		if (!ent_s1.right_ok) begin
			col_sum[2] = '0;
		end
		if (ent_s1.top_ok && ent_s1.bot_ok && ent_s1.left_ok && ent_s1.right_ok) begin
			div_c = DIV_BY_9;
		end else if (!(ent_s1.top_ok && ent_s1.bot_ok) && !(ent_s1.left_ok && ent_s1.right_ok)) begin
			div_c = DIV_BY_4;
		end else begin
			div_c = DIV_BY_6;
		end
	end

	// Stage 3: total, magnitude and half-divisor offset for rounding away from zero.
	always_comb begin
		sum = SUM_W'(colsum_s2[0]) + SUM_W'(colsum_s2[1]) + SUM_W'(colsum_s2[2]);
		mag = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
		case (div_s2)
			DIV_BY_4: bias = BIAS_4;
			DIV_BY_6: bias = BIAS_6;
			DIV_BY_9: bias = BIAS_9;
			default:  bias = BIAS_9;
		endcase
	end

	// Stage 4: divide by six or nine through a reciprocal, by four through a shift.
	always_comb begin
		case (div_s3)
			DIV_BY_6: recip = RECIP_6;
			default:  recip = RECIP_9;
		endcase
		prod = PROD_W'(x_s3) * PROD_W'(recip);
	end

	// Output: restore the sign, or pass the center sample through.
	assign res = neg_s4 ? (QUO_W'(0) - q_s4) : q_s4;

	// Valid bits of every stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			v_s3       <= 1'b0;
			v_s4       <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else if (en) begin
			v_s1       <= pop;
			v_s2       <= v_s1 && ent_s1.emit;
			v_s3       <= v_s2;
			v_s4       <= v_s3;
			m_tvalid_q <= v_s4;
		end
	end

	// Window and stage data.
	always_ff @(posedge clk) begin
		if (pop) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r][0] <= win_q[r][1];
				win_q[r][1] <= win_q[r][2];
			end
			win_q[0][2] <= head.top;
			win_q[1][2] <= head.mid;
			win_q[2][2] <= head.bot;
			ent_s1      <= head;
		end
		if (en) begin
			colsum_s2 <= col_sum;
			div_s2    <= div_c;
			blur_s2   <= ent_s1.blur;
			center_s2 <= win_q[1][1];
			fe_s2     <= ent_s1.fe;

			x_s3      <= MAG_W'(mag) + bias;
			neg_s3    <= sum[SUM_W-1];
			div_s3    <= div_s2;
			blur_s3   <= blur_s2;
			center_s3 <= center_s2;
			fe_s3     <= fe_s2;

			q_s4      <= (div_s3 == DIV_BY_4) ? QUO_W'(x_s3 >> 2) : prod[RECIP_SHIFT +: QUO_W];
			neg_s4    <= neg_s3;
			blur_s4   <= blur_s3;
			center_s4 <= center_s3;
			fe_s4     <= fe_s3;

			m_tdata_q <= blur_s4 ? res[SAMPLE_W-1:0] : SAMPLE_W'(center_s4);
			m_tlast_q <= fe_s4;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	`RBB_ASSERT_IMPLY(a_frame_end_corner, clk, arst_n, v_s1 && ent_s1.fe, ent_s1.emit && !ent_s1.bot_ok && !ent_s1.right_ok, "frame end word is not the bottom right corner")
	`RBB_ASSERT_IMPLY(a_mean_in_range, clk, arst_n, v_s4 && blur_s4, q_s4 <= QUO_W'(32768), "mean magnitude beyond the sample range")

endmodule

FILE: rtl/region_box_blur_3x3.sv
// Top level of the region box blur: register file, front, queue and back.
//
// A matrix of num_rows x num_cols signed Q8.8 samples enters on the s_ channel in
// raster order, one word per sample. Each element inside the programmed inclusive
// rectangle leaves the m_ channel as the rounded mean of itself and its neighbors
// inside the matrix; all other elements leave unchanged. m_tlast marks the last
// element of a frame. Results trail the input by one row and one column.
// Throughput: one sample per cycle inside a row while the queue has room;
// s_tready drops after the last column of a row, and after the last sample of
// a frame while the final row drains. The front sequencer issues one queue word
// per cycle while the queue has room; the output port takes one result per
// cycle while m_tready is high. When the receiver stalls, the back pipeline
// freezes, the four-word queue fills and s_tready drops. Registers are written
// over the APB port by the user only while the block is idle; the block does
// not enforce this. A write of num_rows or num_cols restarts the frame.
// Reset restores the register defaults (4 x 4 matrix, rectangle at element 0,0),
// returns to the first element of a frame and empties the queue and pipeline.
// The line stores are not cleared; no result depends on unwritten entries.
module region_box_blur_3x3
	import rbb_pkg::*;
#(
	parameter int MAX_COLS = 32,
	parameter int MAX_ROWS = 64
)(
	input  logic                clk,
	input  logic                arst_n,
	// APB register port
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	// Sample input
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [SAMPLE_W-1:0] s_tdata,   // [15:0] sample
	// Result output
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [SAMPLE_W-1:0] m_tdata,   // [15:0] value
	output logic                m_tlast    // frame_end
);

	localparam int ROW_W = $clog2(MAX_ROWS);
	localparam int COL_W = $clog2(MAX_COLS);

	logic [6:0]           num_rows_q;
	logic [5:0]           num_cols_q;
	region_t              region_q;
	logic                 wr;
	logic [REG_IDX_W-1:0] reg_idx;
	logic                 restart;
	logic [31:0]          rows_ext;
	logic [31:0]          cols_ext;
	logic [ROW_W-1:0]     row_last;
	logic [COL_W-1:0]     col_last;

	logic                 push;
	entry_t               push_data;
	logic                 pop;
	entry_t               head;
	logic                 empty;
	logic [QCNT_W-1:0]    q_count;

	assign pready  = 1'b1;
	assign wr      = psel && penable && pwrite && pready;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign restart = wr && ((reg_idx == REG_NUM_ROWS) || (reg_idx == REG_NUM_COLS));

	// Register file.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q <= 7'(MIN_DIM);
			num_cols_q <= 6'(MIN_DIM);
			region_q   <= '0;
		end else if (wr) begin
			case (reg_idx)
				REG_NUM_ROWS:  num_rows_q          <= pwdata[6:0];
				REG_NUM_COLS:  num_cols_q          <= pwdata[5:0];
				REG_ROW_FIRST: region_q.row_first <= pwdata[5:0];
				REG_ROW_LAST:  region_q.row_last  <= pwdata[5:0];
				REG_COL_FIRST: region_q.col_first <= pwdata[4:0];
				REG_COL_LAST:  region_q.col_last  <= pwdata[4:0];
				default:       region_q           <= region_q;
			endcase
		end
	end

	// Register readback.
	always_comb begin
		case (reg_idx)
			REG_NUM_ROWS:  prdata = 32'(num_rows_q);
			REG_NUM_COLS:  prdata = 32'(num_cols_q);
			REG_ROW_FIRST: prdata = 32'(region_q.row_first);
			REG_ROW_LAST:  prdata = 32'(region_q.row_last);
			REG_COL_FIRST: prdata = 32'(region_q.col_first);
			REG_COL_LAST:  prdata = 32'(region_q.col_last);
			default:       prdata = '0;
		endcase
	end

	// Matrix size clamped to the supported range, as last row and column index.
	assign rows_ext = 32'(num_rows_q);
	assign cols_ext = 32'(num_cols_q);
	assign row_last = (rows_ext < 32'(MIN_DIM)) ? ROW_W'(MIN_DIM - 1)
		: (rows_ext > 32'(MAX_ROWS)) ? ROW_W'(MAX_ROWS - 1) : ROW_W'(rows_ext - 32'd1);
	assign col_last = (cols_ext < 32'(MIN_DIM)) ? COL_W'(MIN_DIM - 1)
		: (cols_ext > 32'(MAX_COLS)) ? COL_W'(MAX_COLS - 1) : COL_W'(cols_ext - 32'd1);

	rbb_front #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.restart   (restart),
		.row_last  (row_last),
		.col_last  (col_last),
		.region    (region_q),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.q_count   (q_count),
		.push      (push),
		.push_data (push_data)
	);

	rbb_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.empty     (empty),
		.count     (q_count)
	);

	rbb_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.empty    (empty),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

FILE: test/tb_top.sv
// Testbench of the region box blur: directed frames, then random frames checked by a predictor.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import rbb_pkg::*;

	localparam int NCOLS_MAX = 32;
	localparam int NROWS_MAX = 64;
	localparam int DRAIN_CYCLES = 24;
	localparam int RANDOM_ITEMS = 400;
	localparam int HOLD_AT = 150;
	localparam int HOLD_CYCLES = 300;
	localparam int SCRIPT_LEN = 40;

	// One output word as the predictor sees it.
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] value;
		logic                       frame_end;
	} blur_result_t;

	typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

	// One line of the directed script: a register write or a sample, with an
	// optional hand-written value for one of the words the sample causes.
	typedef struct packed {
		row_kind_t                  kind;
		logic [REG_IDX_W-1:0]       reg_idx;
		logic [31:0]                reg_value;
		logic signed [SAMPLE_W-1:0] smp;
		logic                       typed;
		logic [7:0]                 exp_idx;
		logic signed [SAMPLE_W-1:0] exp_value;
		logic                       exp_last;
	} script_row_t;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [31:0]         pwdata;
	logic [31:0]         prdata;
	logic                pready;
	logic                s_tvalid;
	logic                s_tready;
	logic [SAMPLE_W-1:0] s_tdata;   // [15:0] sample
	logic                m_tvalid;
	logic                m_tready;
	logic [SAMPLE_W-1:0] m_tdata;   // [15:0] value
	logic                m_tlast;   // frame_end

	// Predictor copy of the registers and of the filter state.
	logic [6:0] cfg_rows;
	logic [5:0] cfg_cols;
	logic [5:0] cfg_row_first;
	logic [5:0] cfg_row_last;
	logic [4:0] cfg_col_first;
	logic [4:0] cfg_col_last;
	sample_t    line_upper [NCOLS_MAX];
	sample_t    line_lower [NCOLS_MAX];
	int         win [9];
	int         row_pos;
	int         col_pos;

	blur_result_t step_results [$];
	blur_result_t blur_results_q [$];
	script_row_t  script [SCRIPT_LEN];

	int fail_count = 0;
	int samples_in = 0;
	int random_count = 0;
	int burst_left = 0;
	int gap_max = 0;

	region_box_blur_3x3 #(
		.MAX_COLS(NCOLS_MAX),
		.MAX_ROWS(NROWS_MAX)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// The run ends here if the block hangs.
	initial begin
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

	function automatic int eff_rows();
		if (cfg_rows < MIN_DIM) return MIN_DIM;
		if (cfg_rows > NROWS_MAX) return NROWS_MAX;
		return cfg_rows;
	endfunction

	function automatic int eff_cols();
		if (cfg_cols < MIN_DIM) return MIN_DIM;
		if (cfg_cols > NCOLS_MAX) return NCOLS_MAX;
		return cfg_cols;
	endfunction

	function automatic logic [31:0] reg_mask(input logic [REG_IDX_W-1:0] idx);
		case (idx)
			REG_NUM_ROWS: return 32'h7F;
			REG_NUM_COLS, REG_ROW_FIRST, REG_ROW_LAST: return 32'h3F;
			default: return 32'h1F;
		endcase
	endfunction

	// Register side effects: a size write restarts the frame.
	function automatic void apply_register(input logic [REG_IDX_W-1:0] idx,
			input logic [31:0] value);
		case (idx)
			REG_NUM_ROWS: begin
				cfg_rows = value[6:0];
				row_pos = 0;
				col_pos = 0;
			end
			REG_NUM_COLS: begin
				cfg_cols = value[5:0];
				row_pos = 0;
				col_pos = 0;
			end
			REG_ROW_FIRST: cfg_row_first = value[5:0];
			REG_ROW_LAST: cfg_row_last = value[5:0];
			REG_COL_FIRST: cfg_col_first = value[4:0];
			REG_COL_LAST: cfg_col_last = value[4:0];
			default: ;
		endcase
	endfunction

	// Moves the window one column left and puts a new column on the right.
	function automatic void shift_column(input int top, input int mid, input int bot);
		for (int k = 0; k < 3; k++) begin
			win[k*3] = win[k*3+1];
			win[k*3+1] = win[k*3+2];
		end
		win[2] = top;
		win[5] = mid;
		win[8] = bot;
	endfunction

	// Mean of the cells inside the matrix, rounded half away from zero, for
	// elements in the rectangle; the center cell for all others.
	function automatic blur_result_t blur_or_pass(input int blk [9], input bit tv,
			input bit bv, input bit lv, input bit rv, input int i, input int j,
			input bit fe);
		int sum;
		int cnt;
		int mag;
		int quo;
		int v;
		blur_result_t res;
		v = blk[4];
		if (i >= cfg_row_first && i <= cfg_row_last && j >= cfg_col_first &&
				j <= cfg_col_last) begin
			sum = 0;
			cnt = 0;
			for (int a = 0; a < 3; a++) begin
				if ((a == 0 && !tv) || (a == 2 && !bv)) continue;
				for (int b = 0; b < 3; b++) begin
					if ((b == 0 && !lv) || (b == 2 && !rv)) continue;
					sum += blk[a*3+b];
					cnt++;
				end
			end
			mag = (sum < 0) ? -sum : sum;
			quo = (2 * mag + cnt) / (2 * cnt);
			v = (sum < 0) ? -quo : quo;
		end
		res.value = v[SAMPLE_W-1:0];
		res.frame_end = fe;
		return res;
	endfunction

	// Words that one accepted sample causes, left in step_results.
	function automatic void predict_sample(input sample_t s);
		int nr;
		int nc;
		int r;
		int c;
		int up;
		int lo;
		bit lv;
		bit rv;
		int blk [9];
		step_results.delete();
		nr = eff_rows();
		nc = eff_cols();
		r = (row_pos >= nr) ? 0 : row_pos;
		c = (col_pos >= nc) ? 0 : col_pos;
		up = line_upper[c];
		lo = line_lower[c];
		shift_column(up, lo, s);
		line_upper[c] = sample_t'(lo);
		line_lower[c] = s;
		if (r >= 1 && c >= 1)
			step_results.push_back(blur_or_pass(win, r >= 2, 1'b1, c >= 2, 1'b1, r - 1,
				c - 1, 1'b0));
		if (c == nc - 1) begin
			shift_column(0, 0, 0);
			if (r >= 1)
				step_results.push_back(blur_or_pass(win, r >= 2, 1'b1, 1'b1, 1'b0, r - 1, c,
					1'b0));
			// The last sample of a frame also drains the final row.
			if (r == nr - 1) begin
				for (int j = 0; j < nc; j++) begin
					lv = (j >= 1);
					rv = (j + 1 < nc);
					blk[0] = lv ? line_upper[j-1] : 0;
					blk[1] = line_upper[j];
					blk[2] = rv ? line_upper[j+1] : 0;
					blk[3] = lv ? line_lower[j-1] : 0;
					blk[4] = line_lower[j];
					blk[5] = rv ? line_lower[j+1] : 0;
					blk[6] = 0;
					blk[7] = 0;
					blk[8] = 0;
					step_results.push_back(blur_or_pass(blk, 1'b1, 1'b0, lv, rv, r, j,
						j == nc - 1));
				end
			end
			col_pos = 0;
			row_pos = (r + 1 >= nr) ? 0 : r + 1;
		end else begin
			col_pos = c + 1;
			row_pos = r;
		end
	endfunction

	function automatic script_row_t feed(input int smp);
		return '{ROW_SAMPLE, REG_NUM_ROWS, 32'd0, smp[15:0], 1'b0, 8'd0, 16'sd0, 1'b0};
	endfunction

	function automatic script_row_t feed_check(input int smp, input int k, input int v,
			input bit last);
		return '{ROW_SAMPLE, REG_NUM_ROWS, 32'd0, smp[15:0], 1'b1, k[7:0], v[15:0], last};
	endfunction

	function automatic script_row_t set_reg(input logic [REG_IDX_W-1:0] idx, input int v);
		return '{ROW_WRITE, idx, v, 16'sd0, 1'b0, 8'd0, 16'sd0, 1'b0};
	endfunction

	function automatic sample_t random_sample();
		int v;
		case ($urandom_range(0, 7))
			0: v = 32767;
			1: v = -32768;
			2, 3: v = int'($urandom_range(0, 8)) - 4;
			default: v = $urandom_range(0, 65535);
		endcase
		return sample_t'(v);
	endfunction

	// APB write followed by a read back of the same register.
	task automatic write_register(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		apply_register(idx, value);
		@(negedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== (value & reg_mask(idx))) begin
			$error("prdata: expected %0h, got %0h", value & reg_mask(idx), prdata);
			fail_count++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic stop_sending();
		@(negedge clk);
		s_tvalid <= 1'b0;
		burst_left = 0;
	endtask

	// Waits until every expected word has come, then lets the block settle.
	task automatic wait_idle();
		while (blur_results_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Offers one sample in bursts with random gaps and queues what it causes.
	task automatic send_sample(input sample_t smp, input bit typed, input int exp_idx,
			input int exp_value, input bit exp_last);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if (gap_max > 0) begin
				gap = $urandom_range(1, gap_max);
				repeat (gap) @(negedge clk) s_tvalid <= 1'b0;
			end
		end
		burst_left--;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= smp;
		do @(posedge clk); while (!s_tready);
		samples_in++;
		predict_sample(smp);
		if (typed && exp_idx < step_results.size())
			step_results[exp_idx] = '{exp_value[15:0], exp_last};
		foreach (step_results[k]) blur_results_q.push_back(step_results[k]);
	endtask

	// One random phase: new sizes and rectangle, then whole or partial frames.
	task automatic run_random_phase(input int phase);
		int nr;
		int nc;
		int lo;
		int items;
		int budget;
		stop_sending();
		wait_idle();
		gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
		if (phase == 0) begin
			write_register(REG_NUM_ROWS, $urandom_range(0, 3));
			write_register(REG_NUM_COLS, $urandom_range(32, 63));
		end else if (phase == 2) begin
			write_register(REG_NUM_ROWS, $urandom_range(64, 127));
			write_register(REG_NUM_COLS, $urandom_range(0, 4));
		end else if ($urandom_range(0, 3) != 0) begin
			write_register(REG_NUM_ROWS, $urandom_range(0, 7));
			write_register(REG_NUM_COLS, $urandom_range(0, 8));
		end
		nr = eff_rows();
		nc = eff_cols();
		case ($urandom_range(0, 4))
			// Rectangle inside the matrix.
			0: begin
				lo = $urandom_range(0, nr - 1);
				write_register(REG_ROW_FIRST, lo);
				write_register(REG_ROW_LAST, $urandom_range(lo, nr - 1));
				lo = $urandom_range(0, nc - 1);
				write_register(REG_COL_FIRST, lo);
				write_register(REG_COL_LAST, $urandom_range(lo, nc - 1));
			end
			// Any values, often reaching past the matrix or empty.
			1: begin
				write_register(REG_ROW_FIRST, $urandom_range(0, 63));
				write_register(REG_ROW_LAST, $urandom_range(0, 63));
				write_register(REG_COL_FIRST, $urandom_range(0, 31));
				write_register(REG_COL_LAST, $urandom_range(0, 31));
			end
			// Empty on one axis.
			2: begin
				if ($urandom_range(0, 1) == 0) begin
					lo = $urandom_range(1, 63);
					write_register(REG_ROW_FIRST, lo);
					write_register(REG_ROW_LAST, $urandom_range(0, lo - 1));
					write_register(REG_COL_FIRST, 0);
					write_register(REG_COL_LAST, 31);
				end else begin
					lo = $urandom_range(1, 31);
					write_register(REG_ROW_FIRST, 0);
					write_register(REG_ROW_LAST, 63);
					write_register(REG_COL_FIRST, lo);
					write_register(REG_COL_LAST, $urandom_range(0, lo - 1));
				end
			end
			// Whole field range, covering every element.
			3: begin
				write_register(REG_ROW_FIRST, 0);
				write_register(REG_ROW_LAST, 63);
				write_register(REG_COL_FIRST, 0);
				write_register(REG_COL_LAST, 31);
			end
			// A single element.
			default: begin
				lo = $urandom_range(0, nr - 1);
				write_register(REG_ROW_FIRST, lo);
				write_register(REG_ROW_LAST, lo);
				lo = $urandom_range(0, nc - 1);
				write_register(REG_COL_FIRST, lo);
				write_register(REG_COL_LAST, lo);
			end
		endcase
		if (phase == 0 || phase == 2)
			items = nr * nc;
		else if ($urandom_range(0, 3) == 0)
			items = $urandom_range(1, nr * nc);
		else
			items = nr * nc * $urandom_range(1, 2);
		// The wide and the tall phase run whole frames; the others share what is left.
		budget = RANDOM_ITEMS - random_count;
		if (phase == 1)
			budget -= NROWS_MAX * MIN_DIM;
		if (phase != 0 && phase != 2 && items > budget)
			items = (budget < 1) ? 1 : budget;
		repeat (items) send_sample(random_sample(), 1'b0, 0, 0, 1'b0);
		random_count += items;
	endtask

	// Receiver: a changing stall pattern and one long hold-off that fills the block.
	initial begin
		int rx_cycle;
		bit hold_done;
		rx_cycle = 0;
		hold_done = 1'b0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			rx_cycle++;
			if (!hold_done && samples_in >= HOLD_AT) begin
				hold_done = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else begin
				case ((rx_cycle / 97) % 4)
					0: m_tready <= 1'b1;
					1: m_tready <= ($urandom_range(0, 3) != 0);
					2: m_tready <= ((rx_cycle % 5) < 2);
					default: m_tready <= $urandom_range(0, 1);
				endcase
			end
		end
	end

	// Each output word is compared with the oldest expected one.
	always @(posedge clk) begin
		blur_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (blur_results_q.size() == 0) begin
				$error("value: expected nothing, got %0d", $signed(m_tdata));
				fail_count++;
			end else begin
				want = blur_results_q.pop_front();
				if (m_tdata !== want.value) begin
					$error("value: expected %0d, got %0d", $signed(want.value),
						$signed(m_tdata));
					fail_count++;
				end
				if (m_tlast !== want.frame_end) begin
					$error("frame_end: expected %0b, got %0b", want.frame_end, m_tlast);
					fail_count++;
				end
			end
		end
	end

	// Stimulus: reset, the directed script, then random phases.
	initial begin
		int phase;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_rows = 7'd4;
		cfg_cols = 6'd4;
		cfg_row_first = '0;
		cfg_row_last = '0;
		cfg_col_first = '0;
		cfg_col_last = '0;
		foreach (line_upper[k]) line_upper[k] = '0;
		foreach (line_lower[k]) line_lower[k] = '0;
		foreach (win[k]) win[k] = 0;
		row_pos = 0;
		col_pos = 0;
		script = '{
			// Reset sizes, rectangle at the top left element: a corner tie rounds up,
			// the extremes pass through and the final row drains with frame_end.
			feed(1), feed(1), feed(32767), feed(-32768),
			feed(0), feed_check(0, 0, 1, 1'b0), feed(-1), feed_check(-1, 1, -32768, 1'b0),
			feed(32767), feed(32767), feed(-32768), feed(-32768),
			feed(5), feed(-5), feed(256), feed_check(-256, 5, -256, 1'b1),
			// Sizes below range clamp to 4, rectangle reaches past the matrix,
			// a negative corner tie rounds away from zero; the frame stops halfway.
			set_reg(REG_NUM_ROWS, 3), set_reg(REG_NUM_COLS, 0),
			set_reg(REG_ROW_FIRST, 0), set_reg(REG_ROW_LAST, 63),
			set_reg(REG_COL_FIRST, 3), set_reg(REG_COL_LAST, 31),
			feed(7), feed(7), feed(-1), feed(-1),
			feed(7), feed(7), feed(0), feed_check(0, 1, -1, 1'b0),
			// A size write restarts the frame; an empty rectangle blurs nothing.
			set_reg(REG_NUM_COLS, 4), set_reg(REG_ROW_FIRST, 9),
			set_reg(REG_ROW_LAST, 2), set_reg(REG_COL_LAST, 31),
			feed(100), feed(-100), feed(3), feed(3),
			feed(3), feed_check(3, 0, 100, 1'b0)
		};
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		gap_max = 3;
		foreach (script[i]) begin
			if (script[i].kind == ROW_WRITE) begin
				stop_sending();
				wait_idle();
				write_register(script[i].reg_idx, script[i].reg_value);
			end else begin
				send_sample(script[i].smp, script[i].typed, script[i].exp_idx,
					script[i].exp_value, script[i].exp_last);
			end
		end

		phase = 0;
		while (random_count < RANDOM_ITEMS) begin
			run_random_phase(phase);
			phase++;
		end

		stop_sending();
		wait_idle();
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
